/* design/assert_macros.svh */
// Assertion macros shared by the affine masked SM4 engine.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset
`define AMS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define AMS_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define AMS_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/amsm4_pkg.sv */
// Package for the affine masked SM4 engine: constants, types, S-box, map apply.
// No dependencies.
`default_nettype none
package amsm4_pkg;

    localparam int ROUNDS_DEF  = 32;
    localparam int MAP_COUNT   = 168;
    localparam int MAP_WORDS   = 33;
    localparam int MAP_AW      = 8;
    localparam int WORD_AW     = 6;
    localparam int RND_W       = 5;

    localparam logic [MAP_AW-1:0] C_BASE     = 8'd96;
    localparam logic [MAP_AW-1:0] D_BASE     = 8'd128;
    localparam logic [MAP_AW-1:0] ENTRY_BASE = 8'd160;
    localparam logic [MAP_AW-1:0] EXIT_LAST  = 8'd167;

    // Sub-steps of one round
    localparam logic [2:0] SUB_X1 = 3'd0;
    localparam logic [2:0] SUB_X2 = 3'd1;
    localparam logic [2:0] SUB_X3 = 3'd2;
    localparam logic [2:0] SUB_C  = 3'd3;
    localparam logic [2:0] SUB_D  = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ENTRY,
        PH_ROUND,
        PH_EXIT
    } t_phase;

    // 32 rows then the vector
    typedef logic [MAP_WORDS-1:0][31:0] t_map;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Byte-wise S-box on one word
    function automatic logic [31:0] sub_bytes(input logic [31:0] x);
        return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    // Row r drives output bit 31-r by parity, then the vector is XORed in
    function automatic logic [31:0] apply_map(input t_map m, input logic [31:0] x);
        logic [31:0] y;
        for (int r = 0; r < 32; r++) begin
            y[31-r] = ^(m[r] & x);
        end
        return y ^ m[MAP_WORDS-1];
    endfunction

endpackage
`default_nettype wire

/* design/amsm4_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module amsm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 168
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* design/affine_masked_sm4_block_engine.sv */
// Top level of the affine masked SM4 engine: map store, sequencer, shared map unit.
// Depends on amsm4_pkg, amsm4_ram and assert_macros.svh.
//
// Channel   | Signals                                        | Handshake
// request   | i_command i_map_index i_word_index i_load_word | start & !busy
//           | i_block_high i_block_low                       |
// result    | o_result_high o_result_low                     | o_done, one cycle
//
// A load request is written straight into the map store and busy stays low.
// A transform request takes 8 + 5*ROUNDS map steps: one stored map is read
// per cycle across 33 word banks and fed to the single affine map unit.
// Reset is synchronous and clears the sequencer; the map store keeps its
// contents. Results cannot be held off.
`default_nettype none
module affine_masked_sm4_block_engine #(
    parameter int ROUNDS = amsm4_pkg::ROUNDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_map_index,
    input  wire logic [5:0]  i_word_index,
    input  wire logic [31:0] i_load_word,
    input  wire logic [63:0] i_block_high,
    input  wire logic [63:0] i_block_low,
    output logic             o_done,
    output logic [63:0]      o_result_high,
    output logic [63:0]      o_result_low
);
    import amsm4_pkg::*;

    localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);

    // Issue side
    t_phase            r_state, n_state;
    logic [1:0]        r_idx, n_idx;
    logic [RND_W-1:0]  r_round, n_round;
    logic [2:0]        r_sub, n_sub;
    logic [MAP_AW-1:0] rd_addr;

    // Processing side, a registered copy of the issue side
    logic              r_pv;
    t_phase            r_pph;
    logic [1:0]        r_pidx;
    logic [2:0]        r_psub;
    logic              r_done;

    // Datapath
    logic [31:0] r_x [4];
    logic [31:0] r_acc, r_cacc, r_sb;
    logic [31:0] opnd, map_y;
    t_map        w_map;

    logic acc_req, load_req, xfer_req, last_step;

    assign acc_req  = start && !busy;
    assign load_req = acc_req && !i_command;
    assign xfer_req = acc_req && i_command;
    assign busy     = (r_state != PH_IDLE) || r_pv;

    // Map store: one bank per map word, all read at the same map
    for (genvar w = 0; w < MAP_WORDS; w++) begin : g_bank
        logic bank_we;
        assign bank_we = load_req && (i_map_index < MAP_AW'(MAP_COUNT))
                         && (i_word_index == WORD_AW'(w));
        amsm4_ram #(
            .WIDTH(32),
            .DEPTH(MAP_COUNT)
        ) u_bank (
            .i_clk  (i_clk),
            .i_we   (bank_we),
            .i_waddr(i_map_index),
            .i_wdata(i_load_word),
            .i_raddr(rd_addr),
            .o_rdata(w_map[w])
        );
    end

    // Sequencer next state and read address
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_round = r_round;
        n_sub   = r_sub;
        rd_addr = ENTRY_BASE;
        case (r_state)
            PH_IDLE: begin
                if (xfer_req) begin
                    n_state = PH_ENTRY;
                    n_idx   = 2'd0;
                end
            end
            PH_ENTRY: begin
                rd_addr = ENTRY_BASE + MAP_AW'(r_idx);
                n_idx   = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    n_state = PH_ROUND;
                    n_round = '0;
                    n_sub   = SUB_X1;
                end
            end
            PH_ROUND: begin
                case (r_sub)
                    SUB_C:   rd_addr = C_BASE + MAP_AW'(r_round);
                    SUB_D:   rd_addr = D_BASE + MAP_AW'(r_round);
                    default: rd_addr = (MAP_AW'(r_round) << 1) + MAP_AW'(r_round)
                                       + MAP_AW'(r_sub);
                endcase
                if (r_sub == SUB_D) begin
                    n_sub = SUB_X1;
                    if (r_round == LAST_ROUND) begin
                        n_state = PH_EXIT;
                        n_idx   = 2'd0;
                    end else begin
                        n_round = r_round + RND_W'(1);
                    end
                end else begin
                    n_sub = r_sub + 3'd1;
                end
            end
            PH_EXIT: begin
                rd_addr = EXIT_LAST - MAP_AW'(r_idx);
                n_idx   = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    n_state = PH_IDLE;
                end
            end
            default: n_state = PH_IDLE;
        endcase
    end

    // Sequencer and processing-stage control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PH_IDLE;
            r_pv    <= 1'b0;
            r_pph   <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state != PH_IDLE);
            r_pph   <= r_state;
            r_done  <= last_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_round <= n_round;
        r_sub   <= n_sub;
        r_pidx  <= r_idx;
        r_psub  <= r_sub;
    end

    assign last_step = r_pv && (r_pph == PH_EXIT) && (r_pidx == 2'd3);

    // Operand for the shared map unit
    always_comb begin
        case (r_pph)
            PH_ROUND: begin
                case (r_psub)
                    SUB_X1:  opnd = r_x[1];
                    SUB_X2:  opnd = r_x[2];
                    SUB_X3:  opnd = r_x[3];
                    SUB_C:   opnd = r_x[0];
                    default: opnd = r_sb;
                endcase
            end
            default: opnd = r_x[r_pidx];
        endcase
    end

    assign map_y = apply_map(w_map, opnd);

    // Word state update
    always_ff @(posedge i_clk) begin
        if (xfer_req) begin
            r_x[0] <= i_block_high[63:32];
            r_x[1] <= i_block_high[31:0];
            r_x[2] <= i_block_low[63:32];
            r_x[3] <= i_block_low[31:0];
        end else if (r_pv) begin
            case (r_pph)
                PH_ROUND: begin
                    case (r_psub)
                        SUB_X1: r_acc <= map_y;
                        SUB_X2: r_acc <= r_acc ^ map_y;
                        SUB_X3: r_acc <= r_acc ^ map_y;
                        SUB_C: begin
                            r_cacc <= map_y;
                            r_sb   <= sub_bytes(r_acc);
                        end
                        default: begin
                            r_x[0] <= r_x[1];
                            r_x[1] <= r_x[2];
                            r_x[2] <= r_x[3];
                            r_x[3] <= r_cacc ^ map_y;
                        end
                    endcase
                end
                default: r_x[r_pidx] <= map_y;
            endcase
        end
    end

    // Result: reversed word order
    assign o_done        = r_done;
    assign o_result_high = {r_x[3], r_x[2]};
    assign o_result_low  = {r_x[1], r_x[0]};

`include "assert_macros.svh"

    `AMS_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done held for more than one cycle")
    `AMS_IMPLIES(a_done_idle, i_clk, i_rst_n, r_done, !busy, "done while still busy")
    `AMS_NEXT(a_xfer_busy, i_clk, i_rst_n, xfer_req, busy, "transform request did not raise busy")
    `AMS_NEVER(a_sub_range, i_clk, i_rst_n, r_pv && (r_pph == PH_ROUND) && (r_psub > SUB_D), "round sub-step out of range")

endmodule
`default_nettype wire
